>>> rtl/pnch_pkg.sv
// ----------------------------------------------------------------------------
// Player number claim handshake package
// Transaction types and fixed codes shared by the claim handshake modules.
// ----------------------------------------------------------------------------
package pnch_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESCAN   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HANDSHAKE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEEPALIVE = 2'd2;

  // Event kinds on the input channel.
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_START  = 3'd1;
  localparam logic [2:0] MODE_STOP   = 3'd2;
  localparam logic [2:0] MODE_NOTE   = 3'd3;
  localparam logic [2:0] MODE_PACKET = 3'd4;

  // Result kinds on the output channel.
  localparam logic [2:0] KIND_STATE     = 3'd0;
  localparam logic [2:0] KIND_STAGE     = 3'd1;
  localparam logic [2:0] KIND_KEEPALIVE = 3'd2;
  localparam logic [2:0] KIND_REPLY     = 3'd3;
  localparam logic [2:0] KIND_VERDICT   = 3'd4;

  // Failure reasons.
  localparam logic [1:0] FAIL_NONE      = 2'd0;
  localparam logic [1:0] FAIL_NO_ADDR   = 2'd1;
  localparam logic [1:0] FAIL_PRESCAN   = 2'd2;
  localparam logic [1:0] FAIL_BACKOFF   = 2'd3;

  // Most results one event can produce.
  localparam int MAX_RESULTS = 3;

  // Input transaction.
  typedef struct packed {
    logic [2:0] mode;
    logic       interface_ok;
    logic [7:0] peers_present;
    logic       packet_valid;
    logic       is_conflict;
    logic       from_self;
    logic [7:0] number;
  } in_t;

  // Output transaction.
  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] state_code;
    logic [2:0] device_number;
    logic [1:0] iteration;
    logic       first_on_network;
    logic [7:0] peer_count;
    logic [1:0] fail_reason;
    logic       handled;
    logic       last;
  } out_t;

endpackage

>>> rtl/player_number_claim_handshake.sv
// ----------------------------------------------------------------------------
// Player number claim handshake
// Claims a player number on a shared network through a timed handshake and
// defends it once active.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   input     in_valid / in_stall  in_item  (event)
//   output    out_valid/out_stall  out_item (result)
//   config    cfg_we               cfg_index, cfg_data
//
// One event is processed in the cycle it is accepted; its results (up to
// three) are registered and leave one per cycle. A new event is taken as
// soon as the last pending result is leaving, so events that give at most
// one result flow at one per cycle. Reset is synchronous and restores the
// idle state and the default intervals. A stalled output holds the input.
// ----------------------------------------------------------------------------
module player_number_claim_handshake
  import pnch_pkg::*;
#(
  parameter int NUM_PLAYERS = 4,
  parameter int TIMER_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item,
  input  logic cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PRESCAN = 3'd1,
    ST_HELLO   = 3'd2,
    ST_MAC     = 3'd3,
    ST_IP      = 3'd4,
    ST_NUMBER  = 3'd5,
    ST_ACTIVE  = 3'd6,
    ST_FAILED  = 3'd7
  } state_t;

  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);
  localparam logic [NUM_PLAYERS-1:0] ALL_NUMBERS = '1;

  typedef logic [NUM_PLAYERS-1:0] map_t;
  typedef logic [TIMER_BITS-1:0]  timer_t;

  // Clamp an interval into the timer width.
  function automatic timer_t timer_load(input logic [CFG_DATA_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > TIMER_MAX) begin
      return TIMER_MAX[TIMER_BITS-1:0];
    end
    return w[TIMER_BITS-1:0];
  endfunction

  // Map bit of a player number; zero when out of range.
  function automatic map_t number_bit(input logic [7:0] n);
    map_t b;
    b = '0;
    for (int i = 0; i < NUM_PLAYERS; i++) begin
      if (n == 8'(i + 1)) begin
        b[i] = 1'b1;
      end
    end
    return b;
  endfunction

  // Highest number set in a map; zero when empty.
  function automatic logic [2:0] highest(input map_t m);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < NUM_PLAYERS; i++) begin
      if (m[i]) begin
        r = 3'(i + 1);
      end
    end
    return r;
  endfunction

  // Configuration registers.
  logic [CFG_DATA_W-1:0] prescan_ticks;
  logic [CFG_DATA_W-1:0] handshake_ticks;
  logic [CFG_DATA_W-1:0] keepalive_ticks;

  // Machine state.
  state_t     state, state_next;
  logic [2:0] held, held_next;
  map_t       in_use, in_use_next;
  map_t       cand, cand_next;
  logic [2:0] stage, stage_next;
  logic [1:0] rep, rep_next;
  logic       alone, alone_next;
  logic [7:0] peers, peers_next;
  timer_t     st_timer, st_timer_next;
  logic       st_armed, st_armed_next;
  timer_t     ka_timer, ka_timer_next;
  logic       ka_run, ka_run_next;

  // Event results.
  out_t       res [MAX_RESULTS];
  logic [1:0] n;
  out_t       load_items [MAX_RESULTS];
  logic       q_ready;
  logic       in_accept;

  logic       do_finish;
  logic       do_backoff;
  logic       do_advance;
  logic       is_packet;
  logic       handled;
  logic [7:0] contested;
  map_t       avail;
  logic [1:0] stage_len;

  assign in_stall  = !q_ready;
  assign in_accept = in_valid && q_ready;

  // Event processing: one pass from the current state to the next.
  always_comb begin
    state_next    = state;
    held_next     = held;
    in_use_next   = in_use;
    cand_next     = cand;
    stage_next    = stage;
    rep_next      = rep;
    alone_next    = alone;
    peers_next    = peers;
    st_timer_next = st_timer;
    st_armed_next = st_armed;
    ka_timer_next = ka_timer;
    ka_run_next   = ka_run;
    res           = '{default: '0};
    n             = 2'd0;
    do_finish     = 1'b0;
    do_backoff    = 1'b0;
    do_advance    = 1'b0;
    is_packet     = 1'b0;
    handled       = 1'b0;
    contested     = in_item.number;
    avail         = '0;
    stage_len     = 2'd3;

    if (in_accept) begin
      case (in_item.mode)
        MODE_TICK: begin
          // Keep-alive timer runs first.
          if (ka_run) begin
            if (ka_timer <= timer_t'(1)) begin
              res[n] = '{KIND_KEEPALIVE, state_next, held_next, 2'd0, alone_next,
                         peers_next, FAIL_NONE, 1'b0, 1'b0};
              n = n + 2'd1;
              ka_timer_next = timer_load(keepalive_ticks);
            end else begin
              ka_timer_next = ka_timer - timer_t'(1);
            end
          end
          if (st_armed) begin
            if (st_timer <= timer_t'(1)) begin
              st_armed_next = 1'b0;
              st_timer_next = '0;
              if (state == ST_PRESCAN) begin
                do_finish = 1'b1;
              end else begin
                do_advance = 1'b1;
              end
            end else begin
              st_timer_next = st_timer - timer_t'(1);
            end
          end
        end
        MODE_START: begin
          if (state == ST_IDLE || state == ST_FAILED) begin
            if (!in_item.interface_ok) begin
              state_next = ST_FAILED;
              res[n] = '{KIND_STATE, state_next, held_next, 2'd0, alone_next,
                         peers_next, FAIL_NO_ADDR, 1'b0, 1'b0};
              n = n + 2'd1;
            end else begin
              alone_next    = (in_item.peers_present == 8'd0);
              peers_next    = (in_item.peers_present == 8'hFF) ? 8'hFF
                                                               : in_item.peers_present + 8'd1;
              cand_next     = ALL_NUMBERS;
              stage_next    = 3'd0;
              rep_next      = 2'd0;
              state_next    = ST_PRESCAN;
              res[n] = '{KIND_STATE, state_next, held_next, 2'd0, alone_next,
                         peers_next, FAIL_NONE, 1'b0, 1'b0};
              n = n + 2'd1;
              st_timer_next = timer_load(prescan_ticks);
              st_armed_next = 1'b1;
            end
          end
        end
        MODE_STOP: begin
          st_armed_next = 1'b0;
          ka_run_next   = 1'b0;
          held_next     = 3'd0;
          state_next    = ST_IDLE;
          res[n] = '{KIND_STATE, state_next, held_next, 2'd0, alone_next,
                     peers_next, FAIL_NONE, 1'b0, 1'b0};
          n = n + 2'd1;
        end
        MODE_NOTE: begin
          in_use_next = in_use | number_bit(in_item.number);
        end
        MODE_PACKET: begin
          is_packet = 1'b1;
          if (in_item.packet_valid && !in_item.from_self) begin
            if (in_item.is_conflict) begin
              // A conflict on our number before we are active makes us move.
              if (in_item.number == 8'(held) && state != ST_ACTIVE) begin
                do_backoff = 1'b1;
                handled    = 1'b1;
              end
            end else if (in_item.number == 8'(held) && held != 3'd0) begin
              // Another claim on our number: defend it or move.
              handled = 1'b1;
              if (state == ST_ACTIVE) begin
                res[n] = '{KIND_REPLY, state_next, held_next, 2'd0, alone_next,
                           peers_next, FAIL_NONE, 1'b0, 1'b0};
                n = n + 2'd1;
              end else begin
                do_backoff = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    // End of prescan: take the highest free number.
    if (do_finish) begin
      avail = cand_next & ~in_use_next;
      if (avail == '0) begin
        st_armed_next = 1'b0;
        state_next    = ST_FAILED;
        res[n] = '{KIND_STATE, state_next, held_next, 2'd0, alone_next,
                   peers_next, FAIL_PRESCAN, 1'b0, 1'b0};
        n = n + 2'd1;
      end else begin
        held_next  = highest(avail);
        cand_next  = avail & ~number_bit(8'(held_next));
        stage_next = 3'd0;
        rep_next   = 2'd0;
        do_advance = 1'b1;
      end
    end

    // Back-off: mark the contested number and retry from the MAC claim.
    if (do_backoff) begin
      in_use_next   = in_use_next | number_bit(contested);
      st_armed_next = 1'b0;
      cand_next     = cand_next & ~in_use_next;
      if (cand_next == '0) begin
        held_next  = 3'd0;
        state_next = ST_FAILED;
        res[n] = '{KIND_STATE, state_next, held_next, 2'd0, alone_next,
                   peers_next, FAIL_BACKOFF, 1'b0, 1'b0};
        n = n + 2'd1;
      end else begin
        held_next  = highest(cand_next);
        cand_next  = cand_next & ~number_bit(8'(held_next));
        stage_next = 3'd1;
        rep_next   = 2'd0;
        state_next = ST_MAC;
        res[n] = '{KIND_STATE, state_next, held_next, 2'd0, alone_next,
                   peers_next, FAIL_NONE, 1'b0, 1'b0};
        n = n + 2'd1;
        do_advance = 1'b1;
      end
    end

    // Handshake step: send the next stage packet or go active.
    if (do_advance) begin
      if (stage_next >= 3'd4) begin
        st_armed_next = 1'b0;
        state_next    = ST_ACTIVE;
        res[n] = '{KIND_STATE, state_next, held_next, 2'd0, alone_next,
                   peers_next, FAIL_NONE, 1'b0, 1'b0};
        n = n + 2'd1;
        res[n] = '{KIND_KEEPALIVE, state_next, held_next, 2'd0, alone_next,
                   peers_next, FAIL_NONE, 1'b0, 1'b0};
        n = n + 2'd1;
        ka_timer_next = timer_load(keepalive_ticks);
        ka_run_next   = 1'b1;
      end else begin
        stage_len  = (stage_next == 3'd3) ? (alone_next ? 2'd3 : 2'd1) : 2'd3;
        state_next = state_t'(ST_HELLO + stage_next);
        rep_next   = rep_next + 2'd1;
        res[n] = '{KIND_STAGE, state_next, held_next, rep_next, alone_next,
                   peers_next, FAIL_NONE, 1'b0, 1'b0};
        n = n + 2'd1;
        if (rep_next >= stage_len) begin
          stage_next = stage_next + 3'd1;
          rep_next   = 2'd0;
        end
        st_timer_next = timer_load(handshake_ticks);
        st_armed_next = 1'b1;
      end
    end

    // Every packet ends with its verdict.
    if (is_packet) begin
      res[n] = '{KIND_VERDICT, state_next, held_next, 2'd0, alone_next,
                 peers_next, FAIL_NONE, handled, 1'b0};
      n = n + 2'd1;
    end

    // Flag the final result of the event.
    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
  end

  assign load_items[0] = res[0];
  assign load_items[1] = res[1];
  assign load_items[2] = res[2];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prescan_ticks   <= 16'd1000;
      handshake_ticks <= 16'd300;
      keepalive_ticks <= 16'd1500;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESCAN:   prescan_ticks   <= cfg_data;
        CFG_HANDSHAKE: handshake_ticks <= cfg_data;
        CFG_KEEPALIVE: keepalive_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Machine state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      held     <= 3'd0;
      in_use   <= '0;
      cand     <= '0;
      stage    <= 3'd0;
      rep      <= 2'd0;
      alone    <= 1'b0;
      peers    <= 8'd0;
      st_timer <= '0;
      st_armed <= 1'b0;
      ka_timer <= '0;
      ka_run   <= 1'b0;
    end else begin
      state    <= state_next;
      held     <= held_next;
      in_use   <= in_use_next;
      cand     <= cand_next;
      stage    <= stage_next;
      rep      <= rep_next;
      alone    <= alone_next;
      peers    <= peers_next;
      st_timer <= st_timer_next;
      st_armed <= st_armed_next;
      ka_timer <= ka_timer_next;
      ka_run   <= ka_run_next;
    end
  end

  // Results of the accepted event wait here for the output side.
  pnch_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (in_accept),
    .load_count (n),
    .load_items (load_items),
    .ready      (q_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

>>> rtl/pnch_result_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Holds the results of one event and hands them out one per transaction.
// ----------------------------------------------------------------------------
module pnch_result_queue
  import pnch_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic [1:0] load_count,
  input  out_t load_items [MAX_RESULTS],
  output logic ready,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  out_t       q [MAX_RESULTS];
  logic [1:0] cnt;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt != 2'd0);
  assign out_item  = q[0];

  // A new event may load once the queue is empty or its last entry leaves now.
  assign ready = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= load_count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Entries shift toward the head as results are taken.
  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_items;
    end else if (pop) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

endmodule

>>> tb/tb_player_number_claim_handshake.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Player number claim handshake testbench
// Drives start, stop, tick, note and packet events into the claim block with
// random gaps and output stalls. A scoreboard class predicts every result
// transaction from its own copy of the claim state and compares each one,
// field by field, against the block. Phases step through several interval
// settings, the extremes among them, and the run ends by filling the in-use
// map so that the prescan itself fails.
// ----------------------------------------------------------------------------

package claim_tb_pkg;
  import pnch_pkg::*;

  localparam int         PLAYERS     = 4;
  localparam logic [3:0] ALL_NUMBERS = 4'hF;

  // Machine states as they appear in the state_code field.
  typedef enum logic [2:0] {
    ST_IDLE, ST_PRESCAN, ST_HELLO, ST_MAC, ST_IP, ST_NUMBER, ST_ACTIVE, ST_FAILED
  } claim_state_t;

  class claim_tracker;
    // Interval registers.
    logic [15:0]  prescan_len, handshake_len, keepalive_len;
    // Claim state.
    claim_state_t st;
    logic [2:0]   held;
    logic [3:0]   in_use, cands;
    logic [2:0]   stage;
    logic [1:0]   reps;
    logic         alone;
    logic [7:0]   peers;
    logic [15:0]  stage_cnt, ka_cnt;
    logic         stage_on, ka_on;
    // Results expected from the block, oldest first.
    out_t         pending_results[$];
    out_t         batch[$];
    int           failures, n_events, n_checked, n_active, n_backoff, n_failed;

    function new();
      prescan_len   = 16'd1000;
      handshake_len = 16'd300;
      keepalive_len = 16'd1500;
      st        = ST_IDLE;
      held      = 3'd0;
      in_use    = 4'd0;
      cands     = 4'd0;
      stage     = 3'd0;
      reps      = 2'd0;
      alone     = 1'b0;
      peers     = 8'd0;
      stage_cnt = 16'd0;
      ka_cnt    = 16'd0;
      stage_on  = 1'b0;
      ka_on     = 1'b0;
      failures  = 0;
      n_events  = 0;
      n_checked = 0;
      n_active  = 0;
      n_backoff = 0;
      n_failed  = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
      case (idx)
        CFG_PRESCAN:   prescan_len   = value;
        CFG_HANDSHAKE: handshake_len = value;
        CFG_KEEPALIVE: keepalive_len = value;
        default: ;
      endcase
    endfunction

    function logic [3:0] num_bit(logic [7:0] n);
      if (n >= 8'd1 && n <= 8'(PLAYERS)) return 4'(1 << (n - 8'd1));
      return 4'd0;
    endfunction

    function logic [2:0] top_number(logic [3:0] m);
      for (int n = PLAYERS; n >= 1; n--) begin
        if (m[n-1]) return 3'(n);
      end
      return 3'd0;
    endfunction

    // Queue one result; an event never produces more than three.
    function void push(logic [2:0] kind, logic [1:0] iter, logic [1:0] reason,
                       logic handled);
      out_t r;
      if (batch.size() >= MAX_RESULTS) return;
      r.kind             = kind;
      r.state_code       = st;
      r.device_number    = held;
      r.iteration        = iter;
      r.first_on_network = alone;
      r.peer_count       = peers;
      r.fail_reason      = reason;
      r.handled          = handled;
      r.last             = 1'b0;
      batch.push_back(r);
    endfunction

    function void enter(claim_state_t s, logic [1:0] reason);
      st = s;
      if (s == ST_ACTIVE) n_active++;
      if (s == ST_FAILED) n_failed++;
      push(KIND_STATE, 2'd0, reason, 1'b0);
    endfunction

    // Send the next handshake packet, or go active after the last one.
    function void step_stage();
      logic [1:0] need;
      if (stage >= 3'd4) begin
        stage_on = 1'b0;
        enter(ST_ACTIVE, FAIL_NONE);
        push(KIND_KEEPALIVE, 2'd0, FAIL_NONE, 1'b0);
        ka_cnt = keepalive_len;
        ka_on  = 1'b1;
        return;
      end
      need = (stage == 3'd3) ? (alone ? 2'd3 : 2'd1) : 2'd3;
      st   = claim_state_t'(3'(ST_HELLO) + stage);
      reps = reps + 2'd1;
      push(KIND_STAGE, reps, FAIL_NONE, 1'b0);
      if (reps >= need) begin
        stage = stage + 3'd1;
        reps  = 2'd0;
      end
      stage_cnt = handshake_len;
      stage_on  = 1'b1;
    endfunction

    // Prescan over: pick the highest number not known to be taken.
    function void end_prescan();
      logic [3:0] avail;
      avail = cands & ~in_use & ALL_NUMBERS;
      if (avail == 4'd0) begin
        stage_on = 1'b0;
        enter(ST_FAILED, FAIL_PRESCAN);
        return;
      end
      held  = top_number(avail);
      cands = avail & ~num_bit({5'd0, held});
      stage = 3'd0;
      reps  = 2'd0;
      step_stage();
    endfunction

    // Contested number: move to the next free one and redo the MAC claim.
    function void back_off(logic [7:0] contested);
      n_backoff++;
      in_use   = (in_use | num_bit(contested)) & ALL_NUMBERS;
      stage_on = 1'b0;
      cands    = cands & ~in_use & ALL_NUMBERS;
      if (cands == 4'd0) begin
        held = 3'd0;
        enter(ST_FAILED, FAIL_BACKOFF);
        return;
      end
      held  = top_number(cands);
      cands = cands & ~num_bit({5'd0, held});
      stage = 3'd1;
      reps  = 2'd0;
      enter(ST_MAC, FAIL_NONE);
      step_stage();
    endfunction

    function logic packet_acted(in_t ev);
      if (!ev.packet_valid || ev.from_self) return 1'b0;
      if (ev.is_conflict) begin
        if (ev.number == {5'd0, held} && st != ST_ACTIVE) begin
          back_off(ev.number);
          return 1'b1;
        end
        return 1'b0;
      end
      if (ev.number != {5'd0, held} || held == 3'd0) return 1'b0;
      if (st == ST_ACTIVE) begin
        push(KIND_REPLY, 2'd0, FAIL_NONE, 1'b0);
        return 1'b1;
      end
      back_off(ev.number);
      return 1'b1;
    endfunction

    // Accepted event transaction: update the state and queue its results.
    function void note_event(in_t ev);
      out_t r;
      logic hit;
      batch.delete();
      n_events++;
      case (ev.mode)
        MODE_TICK: begin
          // The keep-alive timer runs ahead of the stage timer.
          if (ka_on) begin
            if (ka_cnt <= 16'd1) begin
              push(KIND_KEEPALIVE, 2'd0, FAIL_NONE, 1'b0);
              ka_cnt = keepalive_len;
            end else begin
              ka_cnt = ka_cnt - 16'd1;
            end
          end
          if (stage_on) begin
            if (stage_cnt <= 16'd1) begin
              stage_on  = 1'b0;
              stage_cnt = 16'd0;
              if (st == ST_PRESCAN) end_prescan();
              else step_stage();
            end else begin
              stage_cnt = stage_cnt - 16'd1;
            end
          end
        end
        MODE_START: begin
          if (st == ST_IDLE || st == ST_FAILED) begin
            if (!ev.interface_ok) begin
              enter(ST_FAILED, FAIL_NO_ADDR);
            end else begin
              alone = (ev.peers_present == 8'd0);
              peers = (ev.peers_present == 8'hFF) ? 8'hFF : ev.peers_present + 8'd1;
              cands = ALL_NUMBERS;
              stage = 3'd0;
              reps  = 2'd0;
              enter(ST_PRESCAN, FAIL_NONE);
              stage_cnt = prescan_len;
              stage_on  = 1'b1;
            end
          end
        end
        MODE_STOP: begin
          stage_on = 1'b0;
          ka_on    = 1'b0;
          held     = 3'd0;
          enter(ST_IDLE, FAIL_NONE);
        end
        MODE_NOTE: begin
          in_use = (in_use | num_bit(ev.number)) & ALL_NUMBERS;
        end
        MODE_PACKET: begin
          hit = packet_acted(ev);
          push(KIND_VERDICT, 2'd0, FAIL_NONE, hit);
        end
        default: ;
      endcase
      if (batch.size() > 0) begin
        r      = batch.pop_back();
        r.last = 1'b1;
        batch.push_back(r);
      end
      foreach (batch[i]) pending_results.push_back(batch[i]);
    endfunction

    function string show(out_t r);
      return $sformatf({"kind=%0d state=%0d number=%0d iter=%0d first=%0d ",
                        "peers=%0d reason=%0d handled=%0d last=%0d"},
                       r.kind, r.state_code, r.device_number, r.iteration,
                       r.first_on_network, r.peer_count, r.fail_reason,
                       r.handled, r.last);
    endfunction

    // Accepted result transaction: compare with the oldest expectation.
    function void check_result(out_t got);
      out_t want;
      logic bad;
      n_checked++;
      if (pending_results.size() == 0) begin
        if (failures < 10) $display("ERROR: result with nothing expected: %s", show(got));
        failures++;
        return;
      end
      want = pending_results.pop_front();
      bad  = (got.kind !== want.kind) || (got.state_code !== want.state_code) ||
             (got.device_number !== want.device_number) ||
             (got.iteration !== want.iteration) ||
             (got.first_on_network !== want.first_on_network) ||
             (got.peer_count !== want.peer_count) ||
             (got.fail_reason !== want.fail_reason) ||
             (got.handled !== want.handled) || (got.last !== want.last);
      if (bad) begin
        if (failures < 10) begin
          $display("ERROR: result mismatch");
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
        failures++;
      end
    endfunction
  endclass

endpackage

module tb_player_number_claim_handshake;
  import pnch_pkg::*;
  import claim_tb_pkg::*;

  // The longest correct stretch without a transaction is the long receiver
  // hold plus the random gaps on both channels; the limit is far above it.
  localparam int IDLE_LIMIT    = 2000;
  localparam int LONG_HOLD     = 80;
  localparam int PHASE_ITEMS   = 42;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 10;
  localparam logic [2:0] MODE_TOP = 3'd7;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_t                    in_item   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_item;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  claim_tracker board;
  bit           quiet_tx  = 1'b0;
  bit           quiet_rx  = 1'b0;
  bit           hold_req  = 1'b0;
  int           phases_run = 0;
  int           idle_cycles = 0;

  player_number_claim_handshake dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Offer one event transaction and wait until the block takes it.
  task automatic send(in_t ev);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_event(ev);
  endtask

  // Write all three interval registers back to back.
  task automatic program_intervals(logic [15:0] pre, logic [15:0] hs, logic [15:0] ka);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRESCAN;
    cfg_data  <= pre;
    @(posedge clk);
    board.set_reg(CFG_PRESCAN, pre);
    cfg_index <= CFG_HANDSHAKE;
    cfg_data  <= hs;
    @(posedge clk);
    board.set_reg(CFG_HANDSHAKE, hs);
    cfg_index <= CFG_KEEPALIVE;
    cfg_data  <= ka;
    @(posedge clk);
    board.set_reg(CFG_KEEPALIVE, ka);
    cfg_we <= 1'b0;
  endtask

  // Let every expected result drain, then give the block spare time to settle.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_t mk(logic [2:0] m, logic ok, logic [7:0] pp, logic v,
                             logic c, logic s, logic [7:0] n);
    in_t ev;
    ev.mode          = m;
    ev.interface_ok  = ok;
    ev.peers_present = pp;
    ev.packet_valid  = v;
    ev.is_conflict   = c;
    ev.from_self     = s;
    ev.number        = n;
    return ev;
  endfunction

  // Pick the next event from the current claim state so that most runs get
  // through the whole handshake, with some noise mixed in.
  function automatic in_t random_event();
    in_t         ev;
    logic [31:0] raw;
    int          roll;
    int          sub;
    logic [3:0]  nb;
    raw = $urandom;
    ev  = raw[$bits(in_t)-1:0];
    ev.peers_present = 8'($urandom_range(0, 254));
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      ev.mode = 3'($urandom_range(int'(MODE_PACKET) + 1, int'(MODE_TOP)));
      return ev;
    end
    roll = $urandom_range(0, 99);
    case (board.st)
      ST_IDLE, ST_FAILED:
        ev.mode = roll < 60 ? MODE_START : roll < 75 ? MODE_TICK :
                  roll < 88 ? MODE_PACKET : roll < 95 ? MODE_NOTE : MODE_STOP;
      ST_ACTIVE:
        ev.mode = roll < 68 ? MODE_TICK : roll < 90 ? MODE_PACKET :
                  roll < 93 ? MODE_START : roll < 95 ? MODE_NOTE : MODE_STOP;
      default:
        ev.mode = roll < 76 ? MODE_TICK : roll < 88 ? MODE_PACKET :
                  roll < 93 ? MODE_NOTE : roll < 97 ? MODE_START : MODE_STOP;
    endcase
    sub = $urandom_range(0, 99);
    if (ev.mode == MODE_START) begin
      ev.interface_ok = ($urandom_range(0, 9) != 0);
      if (sub < 40) ev.peers_present = 8'd0;
      else if (sub < 52) ev.peers_present = 8'd254;
    end else if (ev.mode == MODE_PACKET) begin
      ev.packet_valid = ($urandom_range(0, 9) != 0);
      ev.from_self    = ($urandom_range(0, 9) == 0);
      ev.is_conflict  = ($urandom_range(0, 9) < 4);
      if (sub < 60) ev.number = {5'd0, board.held};
      else if (sub < 75) ev.number = 8'd0;
      else if (sub < 90) ev.number = 8'($urandom_range(1, 5));
    end else if (ev.mode == MODE_NOTE) begin
      if (sub < 60) ev.number = 8'($urandom_range(1, PLAYERS));
      else if (sub < 80) ev.number = 8'($urandom_range(0, 7));
    end
    // The in-use map never clears, so keep one number free until the end.
    nb = board.num_bit(ev.number);
    if ((ev.mode == MODE_NOTE || (ev.mode == MODE_PACKET && board.st != ST_ACTIVE)) &&
        nb != 4'd0 && (board.in_use & nb) == 4'd0 && $countones(board.in_use) >= 3)
      ev.number = 8'($urandom_range(5, 255));
    return ev;
  endfunction

  task automatic run_phase(logic [15:0] pre, logic [15:0] hs, logic [15:0] ka);
    program_intervals(pre, hs, ka);
    quiet_tx = (phases_run % 3) != 0;
    quiet_rx = (phases_run % 3) == 1;
    if (phases_run == 0) hold_req = 1'b1;
    for (int i = 0; i < PHASE_ITEMS; i++) send(random_event());
    settle();
    phases_run++;
  endtask

  // Main stimulus.
  initial begin
    in_t plan[$];
    int  leftover;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    program_intervals(16'd1, 16'd1, 16'd1);

    // Directed events: ignored modes, failed start, the packet filters, a
    // contested claim, the path to active, a defended number, and running
    // out of candidates by repeated back-offs from idle.
    plan.push_back(mk(MODE_TOP, 1'b1, 8'd0, 1'b1, 1'b0, 1'b0, 8'd4));
    plan.push_back(mk(MODE_NOTE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd255));
    plan.push_back(mk(MODE_PACKET, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 8'd0));
    plan.push_back(mk(MODE_START, 1'b0, 8'd3, 1'b0, 1'b0, 1'b0, 8'd0));
    plan.push_back(mk(MODE_START, 1'b1, 8'd254, 1'b0, 1'b0, 1'b0, 8'd0));
    plan.push_back(mk(MODE_TICK, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    plan.push_back(mk(MODE_PACKET, 1'b0, 8'd0, 1'b1, 1'b0, 1'b1, 8'd4));
    plan.push_back(mk(MODE_PACKET, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd4));
    plan.push_back(mk(MODE_PACKET, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 8'd4));
    repeat (8) plan.push_back(mk(MODE_TICK, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    plan.push_back(mk(MODE_PACKET, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 8'd3));
    plan.push_back(mk(MODE_PACKET, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 8'd3));
    repeat (3) begin
      plan.push_back(mk(MODE_STOP, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0));
      plan.push_back(mk(MODE_PACKET, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 8'd0));
    end
    plan.push_back(mk(MODE_STOP, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    plan.push_back(mk(MODE_PACKET, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 8'd0));
    foreach (plan[i]) send(plan[i]);
    settle();

    // Random phases over a range of interval settings.
    run_phase(16'd1, 16'd1, 16'd1);
    run_phase(16'd3, 16'd2, 16'd4);
    run_phase(16'd0, 16'd0, 16'd0);
    run_phase(16'd65535, 16'd1, 16'd1);
    run_phase(16'd1, 16'd65535, 16'd1);
    run_phase(16'd2, 16'd1, 16'd65535);
    run_phase(16'd5, 16'd3, 16'd2);

    // Mark every number as in use so that the prescan finds nothing free.
    program_intervals(16'd1, 16'd2, 16'd3);
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
    plan.delete();
    plan.push_back(mk(MODE_STOP, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    for (int n = 1; n <= PLAYERS; n++)
      plan.push_back(mk(MODE_NOTE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'(n)));
    repeat (2) begin
      plan.push_back(mk(MODE_START, 1'b1, 8'd7, 1'b0, 1'b0, 1'b0, 8'd0));
      plan.push_back(mk(MODE_TICK, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    end
    plan.push_back(mk(MODE_STOP, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    foreach (plan[i]) send(plan[i]);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    leftover = board.pending_results.size();
    if (leftover != 0) begin
      $display("ERROR: %0d expected results never arrived", leftover);
      board.failures += leftover;
    end
    $display("Run covered %0d event transactions over %0d interval phases, %0d results checked.",
             board.n_events, phases_run + 2, board.n_checked);
    $display("Claims went active %0d times, with %0d back-offs and %0d failures entered.",
             board.n_active, board.n_backoff, board.n_failed);
    if (board.failures == 0) begin
      $display("tb_player_number_claim_handshake OK");
    end else begin
      $display("tb_player_number_claim_handshake NOT OK");
    end
    $finish;
  end

  // Result receiver: checks each accepted result transaction and stalls at
  // random, once for a long stretch so that the block backs up its input.
  initial begin
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        board.check_result(out_item);
        wait_left = quiet_rx ? 0 : $urandom_range(0, 9);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
      $display("tb_player_number_claim_handshake NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> sim.f
rtl/pnch_pkg.sv
rtl/pnch_result_queue.sv
rtl/player_number_claim_handshake.sv
tb/tb_player_number_claim_handshake.sv
